>>> hw/rtl/gcd_pkg.sv
// shared constants and types of the gronsfeld character decrypter
// no dependencies; imported by every module under hw/rtl

package gcd_pkg;

   localparam int CharW     = 8;
   localparam int DigitW    = 4;
   localparam int KeyDigits = 16;
   localparam int PosW      = 4;
   localparam int LenW      = 5;
   localparam int KeyW      = KeyDigits * DigitW;

   localparam logic [CharW-1:0]  SpaceCode = 8'd32;
   localparam logic [CharW-1:0]  RingALo   = 8'd33;
   localparam logic [CharW-1:0]  RingAHi   = 8'd126;
   localparam logic [CharW-1:0]  RingBLo   = 8'd192;
   localparam logic [CharW-1:0]  RingGap   = 8'd65;
   // 256 - 33: distance that wraps the low segment onto the top of the high one
   localparam logic [CharW-1:0]  RingWrapA = 8'd223;
   localparam logic [DigitW-1:0] MaxDigit  = 4'd9;
   localparam logic [LenW-1:0]   MaxLen    = 5'd16;

   typedef enum logic {
      CSR_KEY_DIGITS = 1'b0,
      CSR_KEY_LENGTH = 1'b1
   } csr_index_type;

   // one ciphertext byte held in the input stage
   typedef struct packed {
      logic [CharW-1:0] in_char;
      logic             line_start;
   } stage_item_type;

endpackage

>>> hw/rtl/gronsfeld_char_decrypt.sv
// top level of the gronsfeld character decrypter: input stage, key and
// ring logic, result register; depends on gcd_pkg, gcd_key_sel, gcd_ring_shift
//
// usage
//  - req channel: one ciphertext byte per transfer on req_tdata, req_tuser
//    set on the first byte of a line (restarts the key at digit zero)
//  - rsp channel: one plaintext byte per input byte, in order
//  - csr port: index 0 writes the 64-bit packed key digits (digit zero in
//    the low nibble), index 1 writes the 5-bit key length; write only while
//    no byte is in flight
//  - path: input register, then the result register that drives rsp
//  - throughput: one byte per cycle while rsp_tready is high; the input
//    and result registers each hold one byte, so two bytes can be in flight
//  - when the receiver stalls, the result register holds its byte and the
//    input register fills; req_tready drops only when both are full
//  - reset clears the key registers, the key position and both valid flags
//  - key position advances when a byte moves from the input register to the
//    result register, so stalls never skip or repeat a digit

module gronsfeld_char_decrypt import gcd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // input stream
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,    // [7:0] in_char
   input  logic              req_tuser,    // [0] line_start
   // result stream
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,    // [7:0] out_char
   // configuration
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [KeyW-1:0]   csr_wdata
);

   logic [KeyW-1:0]    key_digits_ff;
   logic [LenW-1:0]    key_length_ff;

   logic               s1_valid_ff;
   stage_item_type     s1_item_ff;
   logic               out_valid_ff;
   logic [CharW-1:0]   out_char_ff;
   logic [CharW-1:0]   out_char_in;

   logic               out_free;
   logic               s1_advance;
   logic               req_xfer;
   logic [DigitW-1:0]  digit;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_digits_ff <= '0;
         key_length_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_DIGITS: key_digits_ff <= csr_wdata;
            CSR_KEY_LENGTH: key_length_ff <= csr_wdata[LenW-1:0];
            default:        ;
         endcase
      end
   end

   // handshake: result register empties or drains, input stage follows
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_xfer   = req_tvalid && req_tready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_item_ff.in_char    <= req_tdata;
         s1_item_ff.line_start <= req_tuser;
      end
   end

   gcd_key_sel u_key_sel (
      .clock      (clock),
      .reset      (reset),
      .key_digits (key_digits_ff),
      .key_length (key_length_ff),
      .item       (s1_item_ff),
      .advance    (s1_advance),
      .digit      (digit)
   );

   gcd_ring_shift u_ring_shift (
      .in_char  (s1_item_ff.in_char),
      .digit    (digit),
      .out_char (out_char_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_char_ff <= out_char_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;

endmodule

>>> hw/rtl/gcd_key_sel.sv
// key position tracker and key digit selection
// depends on gcd_pkg

module gcd_key_sel import gcd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [KeyW-1:0]      key_digits,
   input  logic [LenW-1:0]      key_length,
   input  stage_item_type       item,
   input  logic                 advance,
   output logic [DigitW-1:0]    digit
);

   logic [PosW-1:0]   pos_ff;
   logic [PosW-1:0]   pos_in;
   logic [LenW-1:0]   len_eff;
   logic [PosW-1:0]   pos_start;
   logic [PosW-1:0]   use_pos;
   logic [DigitW-1:0] nibble;
   logic              is_space;

   always_comb begin
      len_eff   = (key_length > MaxLen) ? MaxLen : key_length;
      pos_start = item.line_start ? '0 : pos_ff;
      use_pos   = ({1'b0, pos_start} >= len_eff) ? '0 : pos_start;
      nibble    = key_digits[use_pos*DigitW +: DigitW];
      is_space  = (item.in_char == SpaceCode);
      if (len_eff == '0 || nibble > MaxDigit) begin
         digit = '0;
      end else begin
         digit = nibble;
      end
      // a space keeps the position but still honors the line restart
      if (is_space) begin
         pos_in = pos_start;
      end else begin
         pos_in = use_pos + PosW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (advance) begin
         pos_ff <= pos_in;
      end
   end

endmodule

>>> hw/rtl/gcd_ring_shift.sv
// moves one byte back along the 158-symbol ring by a key digit
// depends on gcd_pkg

module gcd_ring_shift import gcd_pkg::*; (
   input  logic [CharW-1:0]  in_char,
   input  logic [DigitW-1:0] digit,
   output logic [CharW-1:0]  out_char
);

   logic [CharW:0]   low_a;
   logic [CharW:0]   low_b;
   logic [CharW-1:0] d8;

   always_comb begin
      d8    = CharW'(digit);
      low_a = {1'b0, RingALo} + {1'b0, d8};
      low_b = {1'b0, RingBLo} + {1'b0, d8};
      if (in_char >= RingALo && in_char <= RingAHi) begin
         if ({1'b0, in_char} >= low_a) begin
            out_char = in_char - d8;
         end else begin
            out_char = in_char + RingWrapA - d8;   // wraps to top of high segment
         end
      end else if (in_char >= RingBLo) begin
         if ({1'b0, in_char} >= low_b) begin
            out_char = in_char - d8;
         end else begin
            out_char = in_char - d8 - RingGap;     // wraps to top of low segment
         end
      end else begin
         out_char = in_char;
      end
   end

endmodule
